@@ rtl/gwwm_pkg.sv @@
// shared types and constants of the greedy word wrap measurement block
package gwwm_pkg;

    // character classes carried in the operation field
    localparam logic [2:0] OP_ORDINARY = 3'd0;
    localparam logic [2:0] OP_SPACE    = 3'd1;
    localparam logic [2:0] OP_NEWLINE  = 3'd2;
    localparam logic [2:0] OP_CR       = 3'd3;
    localparam logic [2:0] OP_END      = 3'd4;

    // configuration register indexes
    localparam int CfgIndexWidth = 2;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_LINE_WIDTH = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_LINE_HEIGHT    = 2'd1;

    // reset values of the configuration registers
    localparam logic [30:0] MAX_LINE_WIDTH_RESET = 31'h7FFF_FFFF;
    localparam logic [15:0] LINE_HEIGHT_RESET    = 16'd16;

    // line count saturation point
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        advance;
        logic signed [15:0] kerning;
    } t_in_payload;

    typedef struct packed {
        logic [30:0] widest_width;
        logic [15:0] line_total;
        logic [31:0] total_height;
    } t_out_payload;

    typedef struct packed {
        logic [CfgIndexWidth-1:0] index;
        logic [31:0]              data;
    } t_cfg_payload;

endpackage

@@ rtl/gwwm_chan_if.sv @@
// valid/ready channel interface carrying one payload word
interface gwwm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/greedy_word_wrap_measure.sv @@
// greedy word wrap measurement: per-character line width tracking with wrap
//
//  channel | dir | payload                                  | word accepted when
//  --------+-----+------------------------------------------+---------------------
//  i_in    | in  | operation, advance, kerning              | valid && ready
//  o_out   | out | widest_width, line_total, total_height   | valid && ready
//  i_cfg   | in  | index (0 max_line_width, 1 line_height)  | valid && ready
//
// one character word per cycle; the state registers update at the accept edge
// through one pass of add/compare logic (kerning add, commit add, advance add,
// wrap compare), and an end-of-text word also runs the 16x16 height multiply
// results go into a two-entry output queue, so input keeps flowing while a
// result waits; input stalls only when both entries are full
// end-of-text result appears on o_out the cycle after its word is accepted
// when no earlier result is still waiting in the queue
// i_rst_n is synchronous, active low: clears the line state, the queue and
// restores the register defaults; i_cfg is always ready
module greedy_word_wrap_measure (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gwwm_chan_if.sink          i_in,
    gwwm_chan_if.source        o_out,
    gwwm_chan_if.sink          i_cfg
);

    // configuration registers
    logic [30:0] r_max_width;
    logic [15:0] r_line_height;

    // line state
    logic [31:0] r_committed, n_committed;
    logic [31:0] r_pending,   n_pending;
    logic [31:0] r_space_ws,  n_space_ws;
    logic [31:0] r_widest,    n_widest;
    logic [15:0] r_lines,     n_lines;

    // output queue, entry 0 is the head
    logic                 r_q0_valid, n_q0_valid;
    logic                 r_q1_valid, n_q1_valid;
    gwwm_pkg::t_out_payload r_q0, n_q0;
    gwwm_pkg::t_out_payload r_q1, n_q1;

    logic                 in_ready;
    logic                 in_acc;
    logic                 out_pop;
    logic                 push;
    gwwm_pkg::t_out_payload result;

    // per-character datapath
    logic [31:0] kern_ext;
    logic [31:0] adv_ext;
    logic        line_nz;
    logic        is_space;
    logic        commit;
    logic [31:0] pend_kern;
    logic [31:0] comm_1;
    logic [31:0] pend_2;
    logic [31:0] ws_1;
    logic [31:0] pend_3;
    logic [31:0] ws_2;
    logic [31:0] fit_sum;
    logic        wrap;
    logic [31:0] old_line;
    logic [31:0] carry_pend;
    logic [31:0] line_sum;
    logic [15:0] lines_inc;
    logic [15:0] lines_end;
    logic [31:0] widest_line;
    logic [31:0] widest_old;
    logic [31:0] height;

    assign in_ready    = !r_q1_valid;
    assign i_in.ready  = in_ready;
    assign in_acc      = i_in.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid   = r_q0_valid;
    assign o_out.payload = r_q0;
    assign out_pop       = r_q0_valid && o_out.ready;

    always_comb begin
        kern_ext = {{16{i_in.payload.kerning[15]}}, i_in.payload.kerning};
        adv_ext  = {16'd0, i_in.payload.advance};
        line_nz  = (r_committed != 32'd0) || (r_pending != 32'd0);
        is_space = (i_in.payload.operation == gwwm_pkg::OP_SPACE);

        // kerning only once something stands on the line
        pend_kern = line_nz ? (r_pending + kern_ext) : r_pending;
        // a space moves the pending word onto the line
        commit    = is_space && line_nz;
        comm_1    = commit ? (r_committed + pend_kern) : r_committed;
        pend_2    = commit ? 32'd0 : pend_kern;
        ws_1      = commit ? 32'd0 : r_space_ws;
        pend_3    = pend_2 + adv_ext;
        ws_2      = is_space ? (ws_1 + adv_ext) : ws_1;

        // greedy wrap check against the limit, signed compare
        fit_sum   = comm_1 + pend_3;
        wrap      = (comm_1 != 32'd0) && ($signed(fit_sum) > $signed({1'b0, r_max_width}));
        // space: it carries over alone; ordinary: whitespace stays behind
        old_line   = is_space ? comm_1 : (comm_1 + ws_1);
        carry_pend = is_space ? adv_ext : (pend_3 - ws_1);

        line_sum    = r_committed + r_pending;
        lines_inc   = (r_lines != gwwm_pkg::COUNT_MAX) ? (r_lines + 16'd1) : r_lines;
        // empty last line is not counted at end of text
        lines_end   = line_nz ? r_lines : (r_lines - 16'd1);
        widest_line = ($signed(line_sum) > $signed(r_widest)) ? line_sum : r_widest;
        widest_old  = ($signed(old_line) > $signed(r_widest)) ? old_line : r_widest;
        height      = {16'd0, lines_end} * {16'd0, r_line_height};

        result.widest_width = widest_line[30:0];
        result.line_total   = lines_end;
        result.total_height = height;
    end

    // next line state
    always_comb begin
        n_committed = r_committed;
        n_pending   = r_pending;
        n_space_ws  = r_space_ws;
        n_widest    = r_widest;
        n_lines     = r_lines;
        push        = 1'b0;
        if (in_acc) begin
            unique case (i_in.payload.operation)
                gwwm_pkg::OP_ORDINARY, gwwm_pkg::OP_SPACE: begin
                    if (wrap) begin
                        n_committed = 32'd0;
                        n_pending   = carry_pend;
                        n_space_ws  = 32'd0;
                        n_widest    = widest_old;
                        n_lines     = lines_inc;
                    end else begin
                        n_committed = comm_1;
                        n_pending   = pend_3;
                        n_space_ws  = ws_2;
                    end
                end
                gwwm_pkg::OP_NEWLINE: begin
                    n_committed = 32'd0;
                    n_pending   = 32'd0;
                    n_space_ws  = 32'd0;
                    n_widest    = widest_line;
                    n_lines     = lines_inc;
                end
                gwwm_pkg::OP_END: begin
                    push        = 1'b1;
                    n_committed = 32'd0;
                    n_pending   = 32'd0;
                    n_space_ws  = 32'd0;
                    n_widest    = 32'd0;
                    n_lines     = 16'd1;
                end
                default: begin
                    // carriage return and unused codes leave the state alone
                end
            endcase
        end
    end

    // output queue next state
    always_comb begin
        n_q0_valid = r_q0_valid;
        n_q1_valid = r_q1_valid;
        n_q0       = r_q0;
        n_q1       = r_q1;
        if (out_pop) begin
            n_q0_valid = r_q1_valid;
            n_q0       = r_q1;
            n_q1_valid = 1'b0;
        end
        if (push) begin
            if (!n_q0_valid) begin
                n_q0_valid = 1'b1;
                n_q0       = result;
            end else begin
                n_q1_valid = 1'b1;
                n_q1       = result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= 32'd0;
            r_pending   <= 32'd0;
            r_space_ws  <= 32'd0;
            r_widest    <= 32'd0;
            r_lines     <= 16'd1;
            r_q0_valid  <= 1'b0;
            r_q1_valid  <= 1'b0;
        end else begin
            r_committed <= n_committed;
            r_pending   <= n_pending;
            r_space_ws  <= n_space_ws;
            r_widest    <= n_widest;
            r_lines     <= n_lines;
            r_q0_valid  <= n_q0_valid;
            r_q1_valid  <= n_q1_valid;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width   <= gwwm_pkg::MAX_LINE_WIDTH_RESET;
            r_line_height <= gwwm_pkg::LINE_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                gwwm_pkg::CFG_MAX_LINE_WIDTH: r_max_width   <= i_cfg.payload.data[30:0];
                gwwm_pkg::CFG_LINE_HEIGHT:    r_line_height <= i_cfg.payload.data[15:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

endmodule

@@ rtl/gwwm_checker.sv @@
// port-level checker for the word wrap measurement block, with its bind
module gwwm_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [2:0]             i_in_op,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input gwwm_pkg::t_out_payload i_out_payload
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // a result only follows an end-of-text word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_op == gwwm_pkg::OP_END))
        else $error("result without end of text");

    // an accepted end-of-text word always shows a result next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == gwwm_pkg::OP_END |=> i_out_valid)
        else $error("end of text gave no result");

    // input stalls only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind greedy_word_wrap_measure gwwm_checker u_gwwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.payload.operation),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

@@ tb/greedy_word_wrap_measure_tb.sv @@
// testbench of the greedy word wrap measurement block: directed and random text, checked per word
module greedy_word_wrap_measure_tb;

    // clock and synchronous active-low reset
    logic clk = 1'b0;
    logic rst_n;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // character words in, measurement words out, register writes on a side channel
    gwwm_chan_if #(.t_payload(gwwm_pkg::t_in_payload))  in_ch ();
    gwwm_chan_if #(.t_payload(gwwm_pkg::t_out_payload)) out_ch ();
    gwwm_chan_if #(.t_payload(gwwm_pkg::t_cfg_payload)) cfg_ch ();

    greedy_word_wrap_measure DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // expected measurements, oldest first
    gwwm_pkg::t_out_payload expected_measures[$];

    int error_count     = 0;
    int chars_sent      = 0;
    int measured_chars  = 0;
    int texts_sent      = 0;
    int measures_seen   = 0;
    int burst_left      = 0;
    logic [31:0] stall_cycle = '0;

    // ------------------------------------------------------------------
    // line measurement state kept on the testbench side
    // ------------------------------------------------------------------
    logic [30:0] m_wrap_limit;
    logic [15:0] m_line_height;
    logic [31:0] m_committed;    // width already committed to the current line
    logic [31:0] m_word;         // pending word, including its leading whitespace
    logic [31:0] m_space_run;    // whitespace that opens the pending word
    logic [31:0] m_widest;
    logic [15:0] m_lines;

    function automatic void clear_line_state();
        m_committed = '0;
        m_word      = '0;
        m_space_run = '0;
        m_widest    = '0;
        m_lines     = 16'd1;
    endfunction

    // widest line only grows, compared as signed widths
    function automatic void widen(input logic [31:0] w);
        if ($signed(w) > $signed(m_widest))
            m_widest = w;
    endfunction

    function automatic void bump_lines();
        if (m_lines != gwwm_pkg::COUNT_MAX)
            m_lines = m_lines + 16'd1;
    endfunction

    // advance the line state by one character; returns 1 when a measurement comes out
    function automatic bit measure_char(input gwwm_pkg::t_in_payload w,
                                        output gwwm_pkg::t_out_payload r);
        logic [31:0] adv;
        logic [31:0] kern;
        logic [31:0] line_sum;
        bit is_space;
        adv      = {16'd0, w.advance};
        kern     = {{16{w.kerning[15]}}, w.kerning};
        is_space = (w.operation == gwwm_pkg::OP_SPACE);
        r        = '0;
        case (w.operation)
            gwwm_pkg::OP_NEWLINE: begin
                widen(m_committed + m_word);
                m_committed = '0;
                m_word      = '0;
                m_space_run = '0;
                bump_lines();
                return 1'b0;
            end
            gwwm_pkg::OP_END: begin
                // an empty last line does not count, even on a saturated count
                if (m_word == '0 && m_committed == '0)
                    m_lines = m_lines - 16'd1;
                widen(m_committed + m_word);
                r.widest_width = m_widest[30:0];
                r.line_total   = m_lines;
                r.total_height = {16'd0, m_lines} * {16'd0, m_line_height};
                clear_line_state();
                return 1'b1;
            end
            gwwm_pkg::OP_ORDINARY, gwwm_pkg::OP_SPACE: begin
                // kerning only once something stands on the line
                if (m_committed != '0 || m_word != '0) begin
                    m_word = m_word + kern;
                    if (is_space) begin
                        m_committed = m_committed + m_word;
                        m_word      = '0;
                        m_space_run = '0;
                    end
                end
                m_word = m_word + adv;
                if (is_space)
                    m_space_run = m_space_run + adv;
                line_sum = m_committed + m_word;
                if (m_committed != '0 && $signed(line_sum) > $signed({1'b0, m_wrap_limit})) begin
                    if (is_space) begin
                        // the space itself carries over to the new line
                        m_committed = m_committed + m_word - adv;
                        m_word      = adv;
                    end else begin
                        // leading whitespace stays behind, the word moves down
                        m_committed = m_committed + m_space_run;
                        m_word      = m_word - m_space_run;
                    end
                    widen(m_committed);
                    m_space_run = '0;
                    m_committed = '0;
                    bump_lines();
                end
                return 1'b0;
            end
            default: return 1'b0;    // carriage return and unused codes
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < 100)
            $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk) begin : check_measures
        gwwm_pkg::t_out_payload want;
        gwwm_pkg::t_out_payload got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.payload;
            measures_seen++;
            if (expected_measures.size() == 0) begin
                report_mismatch("measurement word with nothing expected");
            end else begin
                want = expected_measures.pop_front();
                if (got.widest_width !== want.widest_width)
                    report_mismatch($sformatf("widest_width %0d, expected %0d",
                                              got.widest_width, want.widest_width));
                if (got.line_total !== want.line_total)
                    report_mismatch($sformatf("line_total %0d, expected %0d",
                                              got.line_total, want.line_total));
                if (got.total_height !== want.total_height)
                    report_mismatch($sformatf("total_height %0d, expected %0d",
                                              got.total_height, want.total_height));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stalls: always ready, coin flips, one in four, long holds
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        stall_cycle <= stall_cycle + 32'd1;
        case (stall_cycle[9:8])
            2'd0:    out_ch.ready <= 1'b1;
            2'd1:    out_ch.ready <= ($urandom_range(0, 1) == 1);
            2'd2:    out_ch.ready <= (stall_cycle[1:0] == 2'd0);
            default: out_ch.ready <= (stall_cycle[4:0] >= 5'd24);
        endcase
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one character word, sent in bursts with random gaps between them
    task automatic send_char(input logic [2:0] op, input logic [15:0] adv,
                             input logic [15:0] kern);
        gwwm_pkg::t_in_payload  w;
        gwwm_pkg::t_out_payload r;
        int gap;
        w.operation = op;
        w.advance   = adv;
        w.kerning   = kern;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        chars_sent++;
        if (op <= gwwm_pkg::OP_END)
            measured_chars++;
        if (measure_char(w, r))
            expected_measures = {expected_measures, r};
    endtask

    task automatic write_reg(input logic [gwwm_pkg::CfgIndexWidth-1:0] idx,
                             input logic [31:0] value);
        gwwm_pkg::t_cfg_payload c;
        c.index = idx;
        c.data  = value;
        @(negedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= c;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            gwwm_pkg::CFG_MAX_LINE_WIDTH: m_wrap_limit  = value[30:0];
            gwwm_pkg::CFG_LINE_HEIGHT:    m_line_height = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending and let every expected measurement come out
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_measures.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        if (expected_measures.size() != 0) begin
            report_mismatch($sformatf("%0d measurements never came out",
                                      expected_measures.size()));
            expected_measures.delete();
        end
        // let the result path settle: the registered output queue
        repeat (6) @(posedge clk);
    endtask

    // one random text: words, spaces, line breaks, noise codes, then end of text
    task automatic send_text(input int adv_max);
        int n_chars;
        int pick;
        logic [2:0]  op;
        logic [15:0] adv;
        logic [15:0] kern;
        n_chars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        for (int k = 0; k < n_chars; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 64)
                op = gwwm_pkg::OP_ORDINARY;
            else if (pick < 86)
                op = gwwm_pkg::OP_SPACE;
            else if (pick < 93)
                op = gwwm_pkg::OP_NEWLINE;
            else if (pick < 97)
                op = gwwm_pkg::OP_CR;
            else
                op = 3'($urandom_range(gwwm_pkg::OP_END + 1, 7));
            // mostly small glyphs, now and then anything the fields hold
            if ($urandom_range(0, 9) == 0) begin
                adv  = 16'($urandom);
                kern = 16'($urandom);
            end else begin
                adv  = 16'($urandom_range(0, adv_max));
                kern = 16'($urandom_range(0, 6) - 3);
            end
            send_char(op, adv, kern);
        end
        send_char(gwwm_pkg::OP_END, 16'($urandom), 16'($urandom));
        texts_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty text right after reset, then one glyph at the reset register values
    task automatic test_reset_defaults();
        send_char(gwwm_pkg::OP_END, 16'd0, 16'd0);
        send_char(gwwm_pkg::OP_ORDINARY, 16'd3, 16'd0);
        send_char(gwwm_pkg::OP_END, 16'd0, 16'd0);
        drain();
    endtask

    // hand-built line: kerning on an empty line, commit at space, wrap on a
    // glyph, wrap on a space, ignored codes, newline, extreme glyphs
    task automatic test_directed_wrap();
        write_reg(gwwm_pkg::CFG_MAX_LINE_WIDTH, 32'd30);
        write_reg(gwwm_pkg::CFG_LINE_HEIGHT, 32'd10);
        send_char(gwwm_pkg::OP_ORDINARY, 16'd6, 16'd5);     // kerning dropped, line empty
        send_char(gwwm_pkg::OP_ORDINARY, 16'd6, -16'sd2);
        send_char(gwwm_pkg::OP_SPACE, 16'd4, 16'd1);        // word committed
        send_char(gwwm_pkg::OP_ORDINARY, 16'd8, 16'd0);
        send_char(gwwm_pkg::OP_ORDINARY, 16'd8, 16'd0);     // wraps, whitespace left behind
        send_char(gwwm_pkg::OP_SPACE, 16'd4, 16'd0);
        send_char(gwwm_pkg::OP_ORDINARY, 16'd10, 16'd0);    // exactly at the limit
        send_char(gwwm_pkg::OP_SPACE, 16'd3, 16'd0);        // wraps, space carried over
        send_char(gwwm_pkg::OP_CR, 16'd99, 16'd99);
        for (int c = gwwm_pkg::OP_END + 1; c < 8; c++)
            send_char(3'(c), 16'hFFFF, 16'h8000);
        send_char(gwwm_pkg::OP_NEWLINE, 16'd5, 16'd5);
        send_char(gwwm_pkg::OP_ORDINARY, 16'hFFFF, 16'h8000);
        send_char(gwwm_pkg::OP_ORDINARY, 16'd0, 16'h7FFF);
        send_char(gwwm_pkg::OP_SPACE, 16'd0, 16'h8000);     // wraps, nothing left pending
        send_char(gwwm_pkg::OP_END, 16'hFFFF, 16'h7FFF);
        drain();
    endtask

    // wide glyphs against the widest limit; the top bits of both
    // register writes must be dropped
    task automatic test_register_masking();
        write_reg(gwwm_pkg::CFG_MAX_LINE_WIDTH, 32'hFFFF_FFFF);
        write_reg(gwwm_pkg::CFG_LINE_HEIGHT, 32'h0001_0003);
        for (int k = 0; k < 40; k++)
            send_char(gwwm_pkg::OP_SPACE, 16'hFFFF, 16'h7FFF);
        send_char(gwwm_pkg::OP_NEWLINE, 16'd0, 16'd0);
        send_char(gwwm_pkg::OP_ORDINARY, 16'hFFFF, 16'd0);
        send_char(gwwm_pkg::OP_END, 16'd0, 16'd0);
        drain();
    endtask

    // random texts under several register settings, with raw noise in between
    task automatic test_random_texts();
        int start_count;
        int adv_max;
        logic [31:0] limit;
        logic [31:0] height;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin limit = 32'd0;         height = 32'd0;     end
                1: begin limit = 32'h7FFF_FFFF; height = 32'd65535; end
                2, 3: begin
                    limit  = $urandom_range(20, 300);
                    height = $urandom_range(1, 64);
                end
                4: begin limit = $urandom; height = $urandom; end
                default: begin
                    limit  = $urandom_range(0, 60);
                    height = $urandom_range(0, 65535);
                end
            endcase
            write_reg(gwwm_pkg::CFG_MAX_LINE_WIDTH, limit);
            write_reg(gwwm_pkg::CFG_LINE_HEIGHT, height);
            adv_max     = $urandom_range(2, 40);
            start_count = measured_chars;
            while (measured_chars - start_count < 300) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_text(adv_max);
                end else begin
                    repeat ($urandom_range(1, 5))
                        send_char(3'($urandom), 16'($urandom), 16'($urandom));
                end
            end
            // close any half-written text so each phase starts clean
            send_char(gwwm_pkg::OP_END, 16'd0, 16'd0);
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready   = 1'b0;
        m_wrap_limit   = gwwm_pkg::MAX_LINE_WIDTH_RESET;
        m_line_height  = gwwm_pkg::LINE_HEIGHT_RESET;
        clear_line_state();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_wrap();
        test_register_masking();
        test_random_texts();

        drain();
        $display("%0d character words sent, %0d random texts, %0d measurements checked",
                 chars_sent, texts_sent, measures_seen);
        $display("wrap limits 0 to none, line heights 0 to 65535, masked writes, stalls");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ greedy_word_wrap_measure.f @@
rtl/gwwm_pkg.sv
rtl/gwwm_chan_if.sv
rtl/greedy_word_wrap_measure.sv
rtl/gwwm_checker.sv
tb/greedy_word_wrap_measure_tb.sv
